[rtl/assert_macros.svh]
// Assertion helpers; both sample on clk and are disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(name, prop)
`define ASSERT_NEVER(name, cond)
`endif
`endif

[rtl/rvx_pkg.sv]
`default_nettype none
package rvx_pkg;
  localparam int XLEN        = 32;
  localparam int SHW         = $clog2(XLEN);
  localparam int QUEUE_DEPTH = 2;

  typedef logic [XLEN-1:0] word_t;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
    OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM, OP_REMU, OP_ILL
  } op_t;

  typedef struct packed {
    op_t   op;
    word_t a;
    word_t b;
  } entry_t;

  typedef struct packed {
    word_t a;
    word_t b;
    logic  sgn;
    logic  want_rem;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage
`default_nettype wire

[rtl/rvx_if.sv]
`default_nettype none
interface rvx_in_if;
  logic                valid;
  logic                ready;
  logic                func;
  logic [31:0]         inst;
  rvx_pkg::word_t      operand_a;
  rvx_pkg::word_t      operand_b;
  modport source (output valid, func, inst, operand_a, operand_b, input ready);
  modport sink (input valid, func, inst, operand_a, operand_b, output ready);
endinterface

interface rvx_out_if;
  logic           valid;
  logic           ready;
  rvx_pkg::word_t result;
  logic           illegal;
  modport source (output valid, result, illegal, input ready);
  modport sink (input valid, result, illegal, output ready);
endinterface
`default_nettype wire

[rtl/rvx_front.sv]
`default_nettype none
module rvx_front (
  rvx_in_if.sink           req,
  input  wire logic        full,
  output logic             wr,
  output rvx_pkg::entry_t  ent
);
  logic [2:0] f3;
  logic [6:0] f7;
  rvx_pkg::word_t imm;

  assign f3  = req.inst[14:12];
  assign f7  = req.inst[31:25];
  assign imm = {{(rvx_pkg::XLEN-12){req.inst[31]}}, req.inst[31:20]};

  assign req.ready = !full;
  assign wr        = req.valid && !full;

  always_comb begin
    ent.a  = req.operand_a;
    ent.b  = req.func ? imm : req.operand_b;
    ent.op = rvx_pkg::OP_ILL;
    if (req.func) begin
      case (f3)
        rvx_pkg::F3_ADD:  ent.op = rvx_pkg::OP_ADD;
        rvx_pkg::F3_SLT:  ent.op = rvx_pkg::OP_SLT;
        rvx_pkg::F3_SLTU: ent.op = rvx_pkg::OP_SLTU;
        rvx_pkg::F3_XOR:  ent.op = rvx_pkg::OP_XOR;
        rvx_pkg::F3_OR:   ent.op = rvx_pkg::OP_OR;
        rvx_pkg::F3_AND:  ent.op = rvx_pkg::OP_AND;
        rvx_pkg::F3_SLL:  if (f7 == rvx_pkg::F7_BASE) ent.op = rvx_pkg::OP_SLL;
        rvx_pkg::F3_SR: begin
          if (f7 == rvx_pkg::F7_BASE) ent.op = rvx_pkg::OP_SRL;
          else if (f7 == rvx_pkg::F7_ALT) ent.op = rvx_pkg::OP_SRA;
        end
        default: ent.op = rvx_pkg::OP_ILL;
      endcase
    end else begin
      case (f7)
        rvx_pkg::F7_BASE: begin
          case (f3)
            rvx_pkg::F3_ADD:  ent.op = rvx_pkg::OP_ADD;
            rvx_pkg::F3_SLL:  ent.op = rvx_pkg::OP_SLL;
            rvx_pkg::F3_SLT:  ent.op = rvx_pkg::OP_SLT;
            rvx_pkg::F3_SLTU: ent.op = rvx_pkg::OP_SLTU;
            rvx_pkg::F3_XOR:  ent.op = rvx_pkg::OP_XOR;
            rvx_pkg::F3_SR:   ent.op = rvx_pkg::OP_SRL;
            rvx_pkg::F3_OR:   ent.op = rvx_pkg::OP_OR;
            default:          ent.op = rvx_pkg::OP_AND;
          endcase
        end
        rvx_pkg::F7_ALT: begin
          if (f3 == rvx_pkg::F3_ADD) ent.op = rvx_pkg::OP_SUB;
          else if (f3 == rvx_pkg::F3_SR) ent.op = rvx_pkg::OP_SRA;
        end
        rvx_pkg::F7_MULDIV: begin
          case (f3)
            rvx_pkg::F3_MUL:    ent.op = rvx_pkg::OP_MUL;
            rvx_pkg::F3_MULH:   ent.op = rvx_pkg::OP_MULH;
            rvx_pkg::F3_MULHSU: ent.op = rvx_pkg::OP_MULHSU;
            rvx_pkg::F3_MULHU:  ent.op = rvx_pkg::OP_MULHU;
            rvx_pkg::F3_DIV:    ent.op = rvx_pkg::OP_DIV;
            rvx_pkg::F3_DIVU:   ent.op = rvx_pkg::OP_DIVU;
            rvx_pkg::F3_REM:    ent.op = rvx_pkg::OP_REM;
            default:            ent.op = rvx_pkg::OP_REMU;
          endcase
        end
        default: ent.op = rvx_pkg::OP_ILL;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/rvx_queue.sv]
`default_nettype none
module rvx_queue #(
  parameter int DEPTH = rvx_pkg::QUEUE_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  rvx_pkg::entry_t      wdata,
  input  wire logic            rd,
  output rvx_pkg::entry_t      rdata,
  output logic                 not_empty,
  output logic                 full,
  output logic [CW-1:0]        count
);
  rvx_pkg::entry_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;

  assign not_empty = count != '0;
  assign full      = count == CW'(DEPTH);
  assign rdata     = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (rd) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      if (wr && !rd) count <= count + CW'(1);
      else if (rd && !wr) count <= count - CW'(1);
    end
  end
endmodule
`default_nettype wire

[rtl/rvx_div.sv]
`default_nettype none
module rvx_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  rvx_pkg::div_req_t   req,
  input  wire logic           ack,
  output rvx_pkg::word_t      res,
  output rvx_pkg::div_stat_t  stat
);
  localparam int W = rvx_pkg::XLEN;

  rvx_pkg::word_t rem, quo, dvs, ma, mb;
  logic [rvx_pkg::SHW-1:0] cnt;
  logic neg_q, neg_r, want_rem;
  logic [W:0] trial;

  assign ma    = (req.sgn && req.a[W-1]) ? -req.a : req.a;
  assign mb    = (req.sgn && req.b[W-1]) ? -req.b : req.b;
  assign trial = {rem, quo[W-1]} - {1'b0, dvs};

  assign res = want_rem ? (neg_r ? -rem : rem) : (neg_q ? -quo : quo);

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quo      <= ma;
      dvs      <= mb;
      want_rem <= req.want_rem;
      // divide by zero keeps the all-ones quotient unsigned
      neg_q    <= req.sgn && (req.a[W-1] ^ req.b[W-1]) && (req.b != '0);
      neg_r    <= req.sgn && req.a[W-1];
    end else if (stat.busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      cnt       <= '0;
    end else if (stat.busy) begin
      cnt <= cnt + rvx_pkg::SHW'(1);
      if (cnt == rvx_pkg::SHW'(W - 1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end else if (ack) begin
      stat.done <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[rtl/rvx_back.sv]
`default_nettype none
module rvx_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  rvx_pkg::entry_t      head,
  input  wire logic            head_valid,
  output logic                 pop,
  output rvx_pkg::div_stat_t   dstat,
  rvx_out_if.source            rsp
);
  localparam int W = rvx_pkg::XLEN;

  logic is_div, can_load, div_start, div_ack;
  logic out_valid, out_illegal;
  rvx_pkg::word_t out_result, alu_res, div_res;
  rvx_pkg::div_req_t dreq;
  logic [rvx_pkg::SHW-1:0] sh;
  logic signed [W:0] ma, mb;
  logic signed [2*W+1:0] prod;

  assign is_div = head.op inside {rvx_pkg::OP_DIV, rvx_pkg::OP_DIVU,
                                  rvx_pkg::OP_REM, rvx_pkg::OP_REMU};
  assign can_load  = !out_valid || rsp.ready;
  assign div_start = head_valid && is_div && !dstat.busy && !dstat.done;
  assign div_ack   = head_valid && is_div && dstat.done && can_load;
  assign pop       = head_valid && can_load && (!is_div || dstat.done);

  assign dreq.a        = head.a;
  assign dreq.b        = head.b;
  assign dreq.sgn      = head.op == rvx_pkg::OP_DIV || head.op == rvx_pkg::OP_REM;
  assign dreq.want_rem = head.op == rvx_pkg::OP_REM || head.op == rvx_pkg::OP_REMU;

  rvx_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (dreq),
    .ack   (div_ack),
    .res   (div_res),
    .stat  (dstat)
  );

  assign sh = head.b[rvx_pkg::SHW-1:0];
  assign ma = {(head.op == rvx_pkg::OP_MULH || head.op == rvx_pkg::OP_MULHSU) && head.a[W-1],
               head.a};
  assign mb = {head.op == rvx_pkg::OP_MULH && head.b[W-1], head.b};
  assign prod = ma * mb;

  always_comb begin
    case (head.op)
      rvx_pkg::OP_ADD:    alu_res = head.a + head.b;
      rvx_pkg::OP_SUB:    alu_res = head.a - head.b;
      rvx_pkg::OP_SLL:    alu_res = head.a << sh;
      rvx_pkg::OP_SLT:    alu_res = W'($signed(head.a) < $signed(head.b));
      rvx_pkg::OP_SLTU:   alu_res = W'(head.a < head.b);
      rvx_pkg::OP_XOR:    alu_res = head.a ^ head.b;
      rvx_pkg::OP_SRL:    alu_res = head.a >> sh;
      rvx_pkg::OP_SRA:    alu_res = W'($signed(head.a) >>> sh);
      rvx_pkg::OP_OR:     alu_res = head.a | head.b;
      rvx_pkg::OP_AND:    alu_res = head.a & head.b;
      rvx_pkg::OP_MUL:    alu_res = prod[W-1:0];
      rvx_pkg::OP_MULH,
      rvx_pkg::OP_MULHSU,
      rvx_pkg::OP_MULHU:  alu_res = prod[2*W-1:W];
      default:            alu_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (pop) out_valid <= 1'b1;
    else if (rsp.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result  <= is_div ? div_res : alu_res;
      out_illegal <= head.op == rvx_pkg::OP_ILL;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.result  = out_result;
  assign rsp.illegal = out_illegal;
endmodule
`default_nettype wire

[rtl/rv32im_integer_execute_unit.sv]
// Channel  Dir  Payload                              Accepted when
// req      in   func, inst, operand_a, operand_b     req.valid && req.ready
// rsp      out  result, illegal                      rsp.valid && rsp.ready
//
// One transaction per cycle for all ALU and multiply operations while rsp is ready;
// each passes through the queue and the output register. DIV, DIVU, REM, REMU occupy
// the radix-2 divider until their result is handed over; results stay in order.
// Synchronous active-high rst empties the queue and drops any pending result.
// A stalled rsp holds its register; the front keeps accepting until the queue fills.
`default_nettype none
`include "assert_macros.svh"
module rv32im_integer_execute_unit #(
  parameter int QUEUE_DEPTH = rvx_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rvx_in_if.sink     req,
  rvx_out_if.source  rsp
);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rvx_pkg::entry_t wr_ent, head;
  logic wr, full, head_valid, pop;
  logic [CW-1:0] q_count;
  rvx_pkg::div_stat_t dstat;

  rvx_front u_front (
    .req  (req),
    .full (full),
    .wr   (wr),
    .ent  (wr_ent)
  );

  rvx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .wdata     (wr_ent),
    .rd        (pop),
    .rdata     (head),
    .not_empty (head_valid),
    .full      (full),
    .count     (q_count)
  );

  rvx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .dstat      (dstat),
    .rsp        (rsp)
  );

  `ASSERT_PROP(a_queue_bound, q_count <= CW'(QUEUE_DEPTH))
  `ASSERT_NEVER(a_div_busy_done, dstat.busy && dstat.done)
  `ASSERT_PROP(a_illegal_zero, rsp.valid && rsp.illegal |-> rsp.result == '0)
  `ASSERT_PROP(a_div_done_stays, dstat.done && !pop |=> dstat.done)
endmodule
`default_nettype wire
